### src/hct_pkg.sv
`timescale 1ns / 1ps

package hct_pkg;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_X_MIN        = 3'd0;
    localparam logic [2:0] REG_X_MAX        = 3'd1;
    localparam logic [2:0] REG_X_GRID_COUNT = 3'd2;
    localparam logic [2:0] REG_Y_MIN        = 3'd3;
    localparam logic [2:0] REG_Y_MAX        = 3'd4;
    localparam logic [2:0] REG_Y_GRID_COUNT = 3'd5;

    localparam logic signed [15:0] RST_X_MIN   = -16'sd256;
    localparam logic signed [15:0] RST_X_MAX   = 16'sd256;
    localparam logic [8:0]         RST_X_COUNT = 9'd16;
    localparam logic signed [15:0] RST_Y_MIN   = -16'sd256;
    localparam logic signed [15:0] RST_Y_MAX   = 16'sd256;
    localparam logic [8:0]         RST_Y_COUNT = 9'd16;

    localparam int MAX_GRID_DEF    = 256;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int VERTS_PER_CELL  = 6;

    // Width of one cross-product component.
    localparam int CW = 43;

    typedef logic [CW-1:0] t_cw;
    typedef t_cw [2:0] t_cvec;
    typedef logic [15:0] t_nw;
    typedef t_nw [2:0] t_nvec;

    typedef struct packed {
        logic signed [15:0] x_min;
        logic signed [15:0] x_max;
        logic [8:0]         x_grid_count;
        logic signed [15:0] y_min;
        logic signed [15:0] y_max;
        logic [8:0]         y_grid_count;
    } t_cfg;

    typedef struct packed {
        logic [7:0] cell_col;
        logic [7:0] cell_row;
    } t_in;

    typedef struct packed {
        logic [18:0]        vertex_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [23:0]        pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               last;
    } t_out;

    // One classified cell as it travels from the front to the back.
    typedef struct packed {
        logic [18:0]        base;
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        logic signed [15:0] y0;
        logic signed [15:0] y1;
        logic [3:0][23:0]   z;
        t_cvec              c0;
        t_cvec              c1;
    } t_cell;

    // Corner of the cell that each vertex of the cell takes.
    function automatic logic [1:0] corner(input logic [2:0] k);
        logic [1:0] c;
        case (k)
            3'd0: c = 2'd0;
            3'd1: c = 2'd2;
            3'd2: c = 2'd3;
            3'd3: c = 2'd0;
            3'd4: c = 2'd1;
            3'd5: c = 2'd2;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

### src/heightfield_cell_triangulator.sv
`timescale 1ns / 1ps

// Triangulates one cell of a height-field grid on z = x*x + y*y: each pushed
// (column, row) yields six vertex beats, the cell's two triangles, each with
// its buffer index, Q8.8 position, Q16.8 height and Q1.14 face normal; cells
// outside the grid yield nothing. A front pipeline (five stages) accepts a
// cell every cycle unless the queue backs up or the grid steps are being
// recomputed, computes corners, heights and raw cross products, and feeds a
// short queue; the back normalizes both face normals with two units that
// run a bit-serial 32-step square root and a 15-step division, then sends
// the six vertices out through an output register. The back's time per cell
// is set mostly by the square root and division plus the shifts that bring
// the cross product into range; it takes a new cell only after the last
// one's six vertices are loaded, and the front and queue absorb bursts.
// After reset and after every register write, the block recomputes the
// grid steps and holds full high meanwhile. Registers sit at byte addresses
// 0x00 to 0x14: x_min, x_max, x_grid_count, y_min, y_max, y_grid_count. The
// user must write them only while the block is idle; it is not enforced.

module heightfield_cell_triangulator #(
    parameter int MAX_GRID    = hct_pkg::MAX_GRID_DEF,
    parameter int QUEUE_DEPTH = hct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hct_pkg::ADDR_W-1:0] paddr,
    input  logic [hct_pkg::DATA_W-1:0] pwdata,
    output logic [hct_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       push,
    input  hct_pkg::t_in               i_data,
    output logic                       full,
    output logic                       empty,
    input  logic                       pop,
    output hct_pkg::t_out              o_data
);

    hct_pkg::t_cfg  r_cfg;
    logic           cfg_wr;
    logic [2:0]     reg_idx;

    logic           q_push;
    hct_pkg::t_cell q_wdata;
    logic           q_full;
    logic           q_pop;
    hct_pkg::t_cell q_rdata;
    logic           q_empty;

    // The configuration port never waits.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min        <= hct_pkg::RST_X_MIN;
            r_cfg.x_max        <= hct_pkg::RST_X_MAX;
            r_cfg.x_grid_count <= hct_pkg::RST_X_COUNT;
            r_cfg.y_min        <= hct_pkg::RST_Y_MIN;
            r_cfg.y_max        <= hct_pkg::RST_Y_MAX;
            r_cfg.y_grid_count <= hct_pkg::RST_Y_COUNT;
        end else if (cfg_wr) begin
            case (reg_idx)
                hct_pkg::REG_X_MIN:        r_cfg.x_min        <= pwdata[15:0];
                hct_pkg::REG_X_MAX:        r_cfg.x_max        <= pwdata[15:0];
                hct_pkg::REG_X_GRID_COUNT: r_cfg.x_grid_count <= pwdata[8:0];
                hct_pkg::REG_Y_MIN:        r_cfg.y_min        <= pwdata[15:0];
                hct_pkg::REG_Y_MAX:        r_cfg.y_max        <= pwdata[15:0];
                hct_pkg::REG_Y_GRID_COUNT: r_cfg.y_grid_count <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Reads return the raw register bits, zero-extended.
    always_comb begin
        case (reg_idx)
            hct_pkg::REG_X_MIN:        prdata = {16'd0, r_cfg.x_min};
            hct_pkg::REG_X_MAX:        prdata = {16'd0, r_cfg.x_max};
            hct_pkg::REG_X_GRID_COUNT: prdata = {23'd0, r_cfg.x_grid_count};
            hct_pkg::REG_Y_MIN:        prdata = {16'd0, r_cfg.y_min};
            hct_pkg::REG_Y_MAX:        prdata = {16'd0, r_cfg.y_max};
            hct_pkg::REG_Y_GRID_COUNT: prdata = {23'd0, r_cfg.y_grid_count};
            default:                   prdata = '0;
        endcase
    end

    // The front classifies each cell and does all per-corner arithmetic.
    hct_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_wr (cfg_wr),
        .i_push   (push),
        .i_data   (i_data),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    // The queue lets the front keep going while the back normalizes.
    hct_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // The back normalizes both face normals and emits the six vertex beats.
    hct_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_data    (o_data)
    );

endmodule

### src/hct_fifo.sv
`timescale 1ns / 1ps

module hct_fifo #(
    parameter int DEPTH = hct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hct_pkg::t_cell i_data,
    output logic          o_full,
    input  logic          i_pop,
    output hct_pkg::t_cell o_data,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    hct_pkg::t_cell r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CNTW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### src/hct_front.sv
`timescale 1ns / 1ps

module hct_front #(
    parameter int MAX_GRID = hct_pkg::MAX_GRID_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hct_pkg::t_cfg  i_cfg,
    input  logic           i_cfg_wr,
    input  logic           i_push,
    input  hct_pkg::t_in   i_data,
    output logic           o_full,
    output logic           o_q_push,
    output hct_pkg::t_cell o_q_data,
    input  logic           i_q_full
);

    function automatic logic [8:0] eff_count(input logic [8:0] c);
        return (int'(c) > MAX_GRID) ? 9'(MAX_GRID) : c;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
        logic signed [15:0] r;
        if (v > 28'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -28'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic [8:0] cx;
    logic [8:0] cy;

    // Step divider: |max - min| / count, one quotient bit per cycle.
    logic              r_st_load;
    logic              r_st_busy;
    logic [3:0]        r_st_cnt;
    logic [15:0]       r_dvx, r_dvy;
    logic [8:0]        r_remx, r_remy;
    logic [15:0]       r_qx, r_qy;
    logic              r_negx, r_negy;
    logic signed [16:0] r_sx, r_sy;

    logic [16:0] diff_x, diff_y;
    logic [15:0] mag_x, mag_y;
    logic [9:0]  tx, ty;
    logic        gex, gey;
    logic [8:0]  n_remx, n_remy;
    logic [15:0] n_qx, n_qy;

    always_comb begin
        cx = eff_count(i_cfg.x_grid_count);
        cy = eff_count(i_cfg.y_grid_count);
        diff_x = {i_cfg.x_max[15], i_cfg.x_max} - {i_cfg.x_min[15], i_cfg.x_min};
        diff_y = {i_cfg.y_max[15], i_cfg.y_max} - {i_cfg.y_min[15], i_cfg.y_min};
        mag_x = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
        mag_y = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
        tx = {r_remx, r_dvx[15]};
        ty = {r_remy, r_dvy[15]};
        gex = tx >= {1'b0, cx};
        gey = ty >= {1'b0, cy};
        n_remx = gex ? 9'(tx - {1'b0, cx}) : tx[8:0];
        n_remy = gey ? 9'(ty - {1'b0, cy}) : ty[8:0];
        n_qx = {r_qx[14:0], gex};
        n_qy = {r_qy[14:0], gey};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_load <= 1'b1;
            r_st_busy <= 1'b0;
            r_st_cnt  <= '0;
        end else if (i_cfg_wr) begin
            r_st_load <= 1'b1;
            r_st_busy <= 1'b0;
        end else if (r_st_load) begin
            r_st_load <= 1'b0;
            r_st_busy <= 1'b1;
            r_st_cnt  <= '0;
            r_dvx  <= mag_x;
            r_dvy  <= mag_y;
            r_remx <= '0;
            r_remy <= '0;
            r_qx   <= '0;
            r_qy   <= '0;
            r_negx <= diff_x[16];
            r_negy <= diff_y[16];
        end else if (r_st_busy) begin
            r_dvx  <= {r_dvx[14:0], 1'b0};
            r_dvy  <= {r_dvy[14:0], 1'b0};
            r_remx <= n_remx;
            r_remy <= n_remy;
            r_qx   <= n_qx;
            r_qy   <= n_qy;
            r_st_cnt <= r_st_cnt + 1'b1;
            if (r_st_cnt == 4'd15) begin
                r_st_busy <= 1'b0;
                r_sx <= r_negx ? -$signed({1'b0, n_qx}) : $signed({1'b0, n_qx});
                r_sy <= r_negy ? -$signed({1'b0, n_qy}) : $signed({1'b0, n_qy});
            end
        end
    end

    // Cell pipeline, five stages, all moving together.
    logic r_va, r_vb, r_vc, r_vd, r_ve;
    logic en;
    logic accept;
    assign en       = !(r_ve && i_q_full);
    assign o_full   = !en || r_st_load || r_st_busy;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_ve && !i_q_full;

    // Stage A: corner offsets and linear cell number.
    logic [8:0]  col9, row9, col9p, row9p;
    logic        in_range;
    logic signed [26:0] a_px0, a_px1, a_py0, a_py1;
    logic [16:0] a_lin;
    logic signed [26:0] r_px0, r_px1, r_py0, r_py1;
    logic [16:0] r_lin;

    always_comb begin
        col9  = {1'b0, i_data.cell_col};
        row9  = {1'b0, i_data.cell_row};
        col9p = col9 + 9'd1;
        row9p = row9 + 9'd1;
        in_range = (cx >= 9'd2) && (cy >= 9'd2) &&
                   (col9 < cx - 9'd1) && (row9 < cy - 9'd1);
        a_px0 = $signed({1'b0, col9}) * r_sx;
        a_px1 = $signed({1'b0, col9p}) * r_sx;
        a_py0 = $signed({1'b0, row9}) * r_sy;
        a_py1 = $signed({1'b0, row9p}) * r_sy;
        a_lin = 17'(row9) * 17'(cx - 9'd1) + 17'(col9);
    end

    // Stage B: saturated corner coordinates, buffer base index.
    logic signed [15:0] r_bx0, r_bx1, r_by0, r_by1;
    logic [18:0] r_bidx;

    // Stage C: squares.
    logic signed [31:0] sqx0, sqx1, sqy0, sqy1;
    logic [30:0] r_sqx0, r_sqx1, r_sqy0, r_sqy1;
    logic signed [15:0] r_cx0, r_cx1, r_cy0, r_cy1;
    logic [18:0] r_cidx;

    // Stage D: heights and edge deltas.
    logic [31:0] hs0, hs1, hs2, hs3;
    logic [3:0][23:0] r_dz;
    logic signed [16:0] r_ddx, r_ddy;
    logic signed [15:0] r_dx0, r_dx1, r_dy0, r_dy1;
    logic [18:0] r_didx;

    // Stage E: cross-product terms.
    logic signed [24:0] dz1, dz2, dz3;
    logic signed [41:0] r_p_dy_dz3, r_p_dy_dz2, r_p_dx_dz3, r_p_dx_dy;
    logic signed [41:0] r_p_dy_dz1, r_p_dx_dz1, r_p_dx_dz2;
    logic [3:0][23:0] r_ez;
    logic signed [15:0] r_ex0, r_ex1, r_ey0, r_ey1;
    logic [18:0] r_eidx;

    always_comb begin
        sqx0 = r_bx0 * r_bx0;
        sqx1 = r_bx1 * r_bx1;
        sqy0 = r_by0 * r_by0;
        sqy1 = r_by1 * r_by1;
        hs0 = {1'b0, r_sqx0} + {1'b0, r_sqy0};
        hs1 = {1'b0, r_sqx1} + {1'b0, r_sqy0};
        hs2 = {1'b0, r_sqx1} + {1'b0, r_sqy1};
        hs3 = {1'b0, r_sqx0} + {1'b0, r_sqy1};
        dz1 = $signed({1'b0, r_dz[1]}) - $signed({1'b0, r_dz[0]});
        dz2 = $signed({1'b0, r_dz[2]}) - $signed({1'b0, r_dz[0]});
        dz3 = $signed({1'b0, r_dz[3]}) - $signed({1'b0, r_dz[0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (en) begin
            r_va <= accept && in_range;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px0 <= a_px0;
            r_px1 <= a_px1;
            r_py0 <= a_py0;
            r_py1 <= a_py1;
            r_lin <= a_lin;

            r_bx0 <= sat16($signed({{12{i_cfg.x_min[15]}}, i_cfg.x_min}) +
                           $signed({r_px0[26], r_px0}));
            r_bx1 <= sat16($signed({{12{i_cfg.x_min[15]}}, i_cfg.x_min}) +
                           $signed({r_px1[26], r_px1}));
            r_by0 <= sat16($signed({{12{i_cfg.y_min[15]}}, i_cfg.y_min}) +
                           $signed({r_py0[26], r_py0}));
            r_by1 <= sat16($signed({{12{i_cfg.y_min[15]}}, i_cfg.y_min}) +
                           $signed({r_py1[26], r_py1}));
            r_bidx <= 19'({r_lin, 2'b00}) + 19'({r_lin, 1'b0});

            r_sqx0 <= sqx0[30:0];
            r_sqx1 <= sqx1[30:0];
            r_sqy0 <= sqy0[30:0];
            r_sqy1 <= sqy1[30:0];
            r_cx0 <= r_bx0;
            r_cx1 <= r_bx1;
            r_cy0 <= r_by0;
            r_cy1 <= r_by1;
            r_cidx <= r_bidx;

            // Each square is at most 2^30, so the height never needs to saturate.
            r_dz[0] <= hs0[31:8];
            r_dz[1] <= hs1[31:8];
            r_dz[2] <= hs2[31:8];
            r_dz[3] <= hs3[31:8];
            r_ddx <= $signed({r_cx1[15], r_cx1}) - $signed({r_cx0[15], r_cx0});
            r_ddy <= $signed({r_cy1[15], r_cy1}) - $signed({r_cy0[15], r_cy0});
            r_dx0 <= r_cx0;
            r_dx1 <= r_cx1;
            r_dy0 <= r_cy0;
            r_dy1 <= r_cy1;
            r_didx <= r_cidx;

            r_p_dy_dz3 <= r_ddy * dz3;
            r_p_dy_dz2 <= r_ddy * dz2;
            r_p_dx_dz3 <= r_ddx * dz3;
            r_p_dx_dy  <= r_ddx * r_ddy;
            r_p_dy_dz1 <= r_ddy * dz1;
            r_p_dx_dz1 <= r_ddx * dz1;
            r_p_dx_dz2 <= r_ddx * dz2;
            r_ez  <= r_dz;
            r_ex0 <= r_dx0;
            r_ex1 <= r_dx1;
            r_ey0 <= r_dy0;
            r_ey1 <= r_dy1;
            r_eidx <= r_didx;
        end
    end

    always_comb begin
        o_q_data.base = r_eidx;
        o_q_data.x0 = r_ex0;
        o_q_data.x1 = r_ex1;
        o_q_data.y0 = r_ey0;
        o_q_data.y1 = r_ey1;
        o_q_data.z  = r_ez;
        // First face: (p2 - p0) x (p3 - p0).
        o_q_data.c0[0] = 43'(r_p_dy_dz3) - 43'(r_p_dy_dz2);
        o_q_data.c0[1] = -43'(r_p_dx_dz3);
        o_q_data.c0[2] = 43'(r_p_dx_dy);
        // Second face: (p1 - p0) x (p2 - p0).
        o_q_data.c1[0] = -43'(r_p_dy_dz1);
        o_q_data.c1[1] = 43'(r_p_dx_dz1) - 43'(r_p_dx_dz2);
        o_q_data.c1[2] = 43'(r_p_dx_dy);
    end

endmodule

### src/hct_norm.sv
`timescale 1ns / 1ps

module hct_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  hct_pkg::t_cvec i_c,
    output hct_pkg::t_nvec o_n,
    output logic           o_busy
);

    localparam int CW = hct_pkg::CW;
    localparam logic [4:0] ROOT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd14;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_SQ, S_SUM, S_ROOT, S_PREP, S_DIV
    } t_state;

    t_state r_state;
    logic [2:0][CW-1:0] r_m;
    logic [2:0]         r_neg;
    logic [2:0][59:0]   r_sq;
    logic [61:0]        r_v;
    logic [62:0]        r_r;
    logic [62:0]        r_bit;
    logic [30:0]        r_len;
    logic [2:0][44:0]   r_rem;
    logic [44:0]        r_d;
    logic [2:0][14:0]   r_q;
    logic [4:0]         r_cnt;

    logic [2:0][CW-1:0] mag;
    logic               big;
    logic [62:0]        root_t;
    logic               root_ge;
    logic [2:0]         div_ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = i_c[i][CW-1] ? CW'(-i_c[i]) : i_c[i];
            div_ge[i] = r_rem[i] >= r_d;
            if (r_len == '0) begin
                o_n[i] = '0;
            end else if (r_neg[i]) begin
                o_n[i] = -{1'b0, r_q[i]};
            end else begin
                o_n[i] = {1'b0, r_q[i]};
            end
        end
        big = (r_m[0][CW-1:30] != '0) || (r_m[1][CW-1:30] != '0) ||
              (r_m[2][CW-1:30] != '0);
        root_t  = r_r + r_bit;
        root_ge = {1'b0, r_v} >= root_t;
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_m <= mag;
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_c[i][CW-1];
                        end
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (big) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sq[i] <= r_m[i][29:0] * r_m[i][29:0];
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_v   <= 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);
                    r_r   <= '0;
                    r_bit <= 63'(1) << 62;
                    r_cnt <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_ge) begin
                        r_v <= 62'(r_v - root_t);
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ROOT_LAST) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_len <= r_r[30:0];
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= 45'({r_m[i][29:0], 14'd0}) + 45'(r_r[30:1]);
                        r_q[i]   <= '0;
                    end
                    r_d   <= {r_r[30:0], 14'd0};
                    r_cnt <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (div_ge[i]) begin
                            r_rem[i] <= r_rem[i] - r_d;
                        end
                        r_q[i] <= {r_q[i][13:0], div_ge[i]};
                    end
                    r_d   <= r_d >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### src/hct_back.sv
`timescale 1ns / 1ps

module hct_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  hct_pkg::t_cell i_q_data,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output hct_pkg::t_out  o_data
);

    typedef enum logic [1:0] {S_IDLE, S_NORM, S_EMIT} t_state;

    t_state          r_state;
    hct_pkg::t_cell  r_cell;
    logic [2:0]      r_k;
    logic            r_out_vld;
    hct_pkg::t_out   r_out;

    hct_pkg::t_nvec  n0, n1;
    logic            busy0, busy1;
    logic            start;
    logic            load;
    logic [1:0]      cn;
    hct_pkg::t_out   vtx;
    hct_pkg::t_nvec  nsel;

    assign start   = (r_state == S_IDLE) && !i_q_empty;
    assign o_q_pop = start;
    assign o_empty = !r_out_vld;
    assign o_data  = r_out;
    assign load    = (r_state == S_EMIT) && (!r_out_vld || i_pop);

    hct_norm u_norm0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_c     (i_q_data.c0),
        .o_n     (n0),
        .o_busy  (busy0)
    );

    hct_norm u_norm1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_c     (i_q_data.c1),
        .o_n     (n1),
        .o_busy  (busy1)
    );

    always_comb begin
        cn   = hct_pkg::corner(r_k);
        nsel = (r_k < 3'd3) ? n1 : n0;
        vtx.vertex_index = r_cell.base + 19'(r_k);
        vtx.pos_x  = (cn == 2'd0 || cn == 2'd3) ? r_cell.x0 : r_cell.x1;
        vtx.pos_y  = (cn == 2'd0 || cn == 2'd1) ? r_cell.y0 : r_cell.y1;
        vtx.pos_z  = r_cell.z[cn];
        vtx.norm_x = nsel[0];
        vtx.norm_y = nsel[1];
        vtx.norm_z = nsel[2];
        vtx.last   = (r_k == 3'(hct_pkg::VERTS_PER_CELL - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_k       <= '0;
        end else begin
            if (i_pop && r_out_vld && !load) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cell  <= i_q_data;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (!busy0 && !busy1) begin
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_out     <= vtx;
                        r_out_vld <= 1'b1;
                        r_k       <= r_k + 1'b1;
                        if (r_k == 3'(hct_pkg::VERTS_PER_CELL - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/hct_checker.sv
`timescale 1ns / 1ps

module hct_checker
    import hct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              push,
    input  logic              full,
    input  t_in               i_data,
    input  logic              pop,
    input  logic              empty,
    input  t_out              o_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_cells_on,
    output int                o_cells_off,
    output int                o_verts
);

    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } t_vec;

    t_cfg grid;
    t_out vertex_q[$];

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint surface_z(input longint x, input longint y);
        longint z;
        z = (x * x + y * y) / 256;
        return (z > 64'hFFFFFF) ? 64'hFFFFFF : z;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Cross product a x b, scaled to a unit vector in Q1.14.
    function automatic t_vec unit_normal(input t_vec a, input t_vec b);
        longint c[3];
        longint unsigned m[3];
        longint unsigned len;
        longint q;
        t_vec n;
        c[0] = a.y * b.z - a.z * b.y;
        c[1] = a.z * b.x - a.x * b.z;
        c[2] = a.x * b.y - a.y * b.x;
        for (int i = 0; i < 3; i++) m[i] = (c[i] < 0) ? -c[i] : c[i];
        while (m[0] >= (64'd1 << 30) || m[1] >= (64'd1 << 30) || m[2] >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            if (len == 0) q = 0;
            else q = (m[i] * 16384 + len / 2) / len;
            c[i] = (c[i] < 0) ? -q : q;
        end
        n.x = c[0];
        n.y = c[1];
        n.z = c[2];
        return n;
    endfunction

    // Builds the six vertex beats of one cell, or nothing when it is off the grid.
    task automatic triangulate(input t_in item);
        longint cx, cy, sx, sy, x0, x1, y0, y1, col, row;
        longint px[4], py[4], pz[4];
        t_vec r0, r1, r2, n0, n1, n;
        t_out v;
        logic [1:0] cn;
        col = item.cell_col;
        row = item.cell_row;
        cx = (grid.x_grid_count > MAX_GRID_DEF) ? MAX_GRID_DEF : grid.x_grid_count;
        cy = (grid.y_grid_count > MAX_GRID_DEF) ? MAX_GRID_DEF : grid.y_grid_count;
        if (cx < 2 || cy < 2 || col >= cx - 1 || row >= cy - 1) begin
            o_cells_off++;
            return;
        end
        o_cells_on++;
        sx = (longint'(grid.x_max) - longint'(grid.x_min)) / cx;
        sy = (longint'(grid.y_max) - longint'(grid.y_min)) / cy;
        x0 = clamp16(grid.x_min + col * sx);
        x1 = clamp16(grid.x_min + (col + 1) * sx);
        y0 = clamp16(grid.y_min + row * sy);
        y1 = clamp16(grid.y_min + (row + 1) * sy);
        px[0] = x0; py[0] = y0;
        px[1] = x1; py[1] = y0;
        px[2] = x1; py[2] = y1;
        px[3] = x0; py[3] = y1;
        for (int i = 0; i < 4; i++) pz[i] = surface_z(px[i], py[i]);
        r0 = '{px[3] - px[0], py[3] - py[0], pz[3] - pz[0]};
        r1 = '{px[2] - px[0], py[2] - py[0], pz[2] - pz[0]};
        r2 = '{px[1] - px[0], py[1] - py[0], pz[1] - pz[0]};
        n0 = unit_normal(r1, r0);
        n1 = unit_normal(r2, r1);
        for (int k = 0; k < VERTS_PER_CELL; k++) begin
            cn = corner(k[2:0]);
            n = (k < 3) ? n1 : n0;
            v.vertex_index = 19'((row * (cx - 1) + col) * VERTS_PER_CELL + k);
            v.pos_x = 16'(px[cn]);
            v.pos_y = 16'(py[cn]);
            v.pos_z = 24'(pz[cn]);
            v.norm_x = 16'(n.x);
            v.norm_y = 16'(n.y);
            v.norm_z = 16'(n.z);
            v.last = (k == VERTS_PER_CELL - 1);
            vertex_q.insert(vertex_q.size(), v);
        end
    endtask

    task automatic compare_vertex(input t_out got);
        t_out exp;
        o_verts++;
        if (vertex_q.size() == 0) begin
            o_errors++;
            $error("vertex beat %0h with no cell pending", got);
            return;
        end
        exp = vertex_q.pop_front();
        if (got.vertex_index !== exp.vertex_index) begin
            o_errors++;
            $error("vertex_index exp %0d got %0d", exp.vertex_index, got.vertex_index);
        end
        if (got.pos_x !== exp.pos_x) begin
            o_errors++;
            $error("pos_x exp %0d got %0d", exp.pos_x, got.pos_x);
        end
        if (got.pos_y !== exp.pos_y) begin
            o_errors++;
            $error("pos_y exp %0d got %0d", exp.pos_y, got.pos_y);
        end
        if (got.pos_z !== exp.pos_z) begin
            o_errors++;
            $error("pos_z exp %0d got %0d", exp.pos_z, got.pos_z);
        end
        if (got.norm_x !== exp.norm_x) begin
            o_errors++;
            $error("norm_x exp %0d got %0d", exp.norm_x, got.norm_x);
        end
        if (got.norm_y !== exp.norm_y) begin
            o_errors++;
            $error("norm_y exp %0d got %0d", exp.norm_y, got.norm_y);
        end
        if (got.norm_z !== exp.norm_z) begin
            o_errors++;
            $error("norm_z exp %0d got %0d", exp.norm_z, got.norm_z);
        end
        if (got.last !== exp.last) begin
            o_errors++;
            $error("last exp %0d got %0d", exp.last, got.last);
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_cells_on = 0;
        o_cells_off = 0;
        o_verts = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid.x_min <= RST_X_MIN;
            grid.x_max <= RST_X_MAX;
            grid.x_grid_count <= RST_X_COUNT;
            grid.y_min <= RST_Y_MIN;
            grid.y_max <= RST_Y_MAX;
            grid.y_grid_count <= RST_Y_COUNT;
        end else begin
            if (pop && !empty) compare_vertex(o_data);
            if (push && !full) triangulate(i_data);
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_X_MIN:        grid.x_min <= pwdata[15:0];
                    REG_X_MAX:        grid.x_max <= pwdata[15:0];
                    REG_X_GRID_COUNT: grid.x_grid_count <= pwdata[8:0];
                    REG_Y_MIN:        grid.y_min <= pwdata[15:0];
                    REG_Y_MAX:        grid.y_max <= pwdata[15:0];
                    REG_Y_GRID_COUNT: grid.y_grid_count <= pwdata[8:0];
                    default: ;
                endcase
            end
        end
        o_pending <= vertex_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the height-field cell triangulator. The checker
// beside the block predicts every vertex beat; this module only feeds cells,
// programs the grid between phases and judges the run.
module tb_top;
    import hct_pkg::*;

    // Generous bound for about 120 cells, with stalls.
    localparam int CYCLE_LIMIT = 400000;
    // Settling time before a register write; off-grid cells leave no trace
    // in the checker, and the front pipeline drops them before the queue.
    localparam int SETTLE = 150;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push, full, empty, pop;
    t_in               i_data;
    t_out              o_data;

    int errors, pending, cells_on, cells_off, verts;
    int cycles;
    // While calm is set neither side idles.
    logic calm;

    heightfield_cell_triangulator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .i_data(i_data), .full(full),
        .empty(empty), .pop(pop), .o_data(o_data)
    );

    hct_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .push(push), .full(full), .i_data(i_data),
        .pop(pop), .empty(empty), .o_data(o_data),
        .o_errors(errors), .o_pending(pending), .o_cells_on(cells_on),
        .o_cells_off(cells_off), .o_verts(verts)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls about a quarter of the time unless the run is calm.
    always @(posedge i_clk) begin
        pop <= calm || ($urandom_range(99) >= 24);
    end

    // Watchdog: a hung block must not stall the run forever.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // One APB write: setup cycle, then the access cycle commits it.
    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Drops push, waits for every predicted beat and lets the back go quiet.
    task automatic drain;
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_grid(input int xmin, input int xmax, input int xcnt,
                            input int ymin, input int ymax, input int ycnt);
        drain();
        reg_write(REG_X_MIN, 32'(xmin));
        reg_write(REG_X_MAX, 32'(xmax));
        reg_write(REG_X_GRID_COUNT, 32'(xcnt));
        reg_write(REG_Y_MIN, 32'(ymin));
        reg_write(REG_Y_MAX, 32'(ymax));
        reg_write(REG_Y_GRID_COUNT, 32'(ycnt));
    endtask

    // Offers one cell and returns once it is taken; push stays high so the
    // next cell can follow back to back.
    task automatic send_cell(input int col, input int row);
        if (!calm && $urandom_range(99) < 24) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_data.cell_col <= 8'(col);
        i_data.cell_row <= 8'(row);
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // A random grid, small counts mostly so most cells land on the grid.
    task automatic random_phase(input int n_cells, input bit big);
        int cx, cy;
        cx = big ? $urandom_range(2, 300) : $urandom_range(2, 12);
        cy = big ? $urandom_range(2, 300) : $urandom_range(2, 12);
        set_grid($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768, cx,
                 $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768, cy);
        if (cx > MAX_GRID_DEF) cx = MAX_GRID_DEF;
        if (cy > MAX_GRID_DEF) cy = MAX_GRID_DEF;
        for (int i = 0; i < n_cells; i++) begin
            if ($urandom_range(9) == 0)
                send_cell($urandom_range(0, 255), $urandom_range(0, 255));
            else
                send_cell($urandom_range(0, cx - 2), $urandom_range(0, cy - 2));
        end
    endtask

    initial begin
        cycles = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        pop = 1'b0;
        i_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default grid: corners, the last cell, and cells just off the grid.
        send_cell(0, 0);
        send_cell(14, 14);
        send_cell(15, 0);
        send_cell(0, 15);
        send_cell(255, 255);

        // Widest x range with the fewest divisions; y runs backward over
        // the full range and uses the largest count.
        set_grid(-32768, 32767, 2, 32767, -32768, 256);
        send_cell(0, 0);
        send_cell(0, 254);
        send_cell(0, 170);
        send_cell(1, 0);
        send_cell(0, 255);

        // A count above the limit is clamped; zero-width ranges collapse the
        // cell to a point, so both normals have zero length.
        set_grid(100, 100, 511, -40, -40, 3);
        send_cell(0, 0);
        send_cell(254, 1);
        send_cell(255, 0);

        // Counts of zero and one leave an axis without cells.
        set_grid(-256, 256, 1, -256, 256, 16);
        send_cell(0, 0);
        set_grid(-256, 256, 16, -256, 256, 0);
        send_cell(0, 0);
        send_cell(85, 170);

        // Random grids and cells; one phase runs with no idling at all, and
        // in another the sender waits once for the block to drain.
        random_phase(20, 1'b0);
        calm = 1'b1;
        random_phase(20, 1'b0);
        calm = 1'b0;
        random_phase(10, 1'b0);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int i = 0; i < 10; i++) send_cell($urandom_range(0, 3), $urandom_range(0, 3));
        random_phase(20, 1'b1);
        random_phase(20, 1'b0);

        drain();
        $display("Covered %0d cells on the grid and %0d off it, %0d vertex beats checked.",
                 cells_on, cells_off, verts);
        $display("Grids spanned the full coordinate range, reversed axes and clamped counts.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
src/hct_pkg.sv
src/hct_fifo.sv
src/hct_front.sv
src/hct_norm.sv
src/hct_back.sv
src/heightfield_cell_triangulator.sv
tb/hct_checker.sv
tb/tb_top.sv
